// ===== rtl/core/masel_pkg.sv =====
// Shared types, constants and per-pixel helper functions for the 2x2 mip reducer.
package masel_pkg;

	localparam int CHAN_N   = 4;
	localparam int CHAN_W   = 8;
	localparam int PIX_W    = CHAN_N * CHAN_W;
	localparam int ERR_W    = 18;  // four squared 9-bit differences
	localparam int CFG_W    = 11;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	// register index, taken from the word address bits of paddr
	localparam logic REG_IMAGE_WIDTH = 1'b0;
	localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST = 11'd2;

	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [ERR_W-1:0]  err_t;

	// channel k of a packed pixel
	function automatic chan_t chan_of(input pix_t p, input int k);
		chan_of = p[k*CHAN_W +: CHAN_W];
	endfunction

	// per-channel floor average of four pixels, packed like a pixel
	function automatic pix_t block_avg(input pix_t p0, input pix_t p1,
	                                   input pix_t p2, input pix_t p3);
		logic [CHAN_W+1:0] sum;
		pix_t avg;
		avg = '0;
		for (int k = 0; k < CHAN_N; k++) begin
			sum = {2'b00, chan_of(p0, k)} + {2'b00, chan_of(p1, k)}
			    + {2'b00, chan_of(p2, k)} + {2'b00, chan_of(p3, k)};
			avg[k*CHAN_W +: CHAN_W] = sum[CHAN_W+1:2];
		end
		block_avg = avg;
	endfunction

	// sum of squared channel differences between a pixel and the average
	function automatic err_t sq_err(input pix_t p, input pix_t avg);
		logic signed [CHAN_W:0]     d;
		logic signed [2*CHAN_W+1:0] sq;
		err_t acc;
		acc = '0;
		for (int k = 0; k < CHAN_N; k++) begin
			d   = $signed({1'b0, chan_of(p, k)}) - $signed({1'b0, chan_of(avg, k)});
			sq  = d * d;
			acc = acc + {2'b00, sq[2*CHAN_W-1:0]};
		end
		sq_err = acc;
	endfunction

endpackage

// ===== rtl/core/mip_average_select_2x2_unit.sv =====
// Top level of the 2x2 mip reducer: position tracking, line store and result pipeline.
//
// Usage: source pixels enter on the in_* channel in raster order, one transfer per
// pixel, with frame_start set on the first pixel of a frame. Each transfer of the
// bottom-right pixel of a 2x2 block (odd column of an odd row) yields one result on
// the out_* channel; every other transfer yields none. row_end marks the last
// result of an output row. image_width (APB, byte address 0) sets the source width;
// its low bit is dropped and it is clamped to 2..MAX_WIDTH. Write it only while idle.
// Throughput: one source pixel per cycle while in_stall is low; the line store is a single
// memory written on even rows and read on odd rows, at most one access per transfer.
// Result path: the bottom-right pixel's block passes the line read, average, error and
// select/output register stages in that order before out_valid rises.
// Backpressure: out_stall holds the output register; the pipeline keeps accepting
// into empty stages and raises in_stall only when all stages hold results and
// out_stall is high.
// Reset: clears position, row parity, held pixel, pipeline valids and sets
// image_width to 2. The line store is not cleared; each odd row reads only
// pairs written by the even row before it.
module mip_average_select_2x2_unit #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [masel_pkg::APB_AW-1:0] paddr,
	input  logic [masel_pkg::APB_DW-1:0] pwdata,
	output logic [masel_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	// source pixels
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [31:0]                src_pixel,
	input  logic                       frame_start,
	// reduced pixels
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [31:0]                mip_pixel,
	output logic                       row_end
);
	import masel_pkg::*;

	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int COL_W      = ($clog2(MAX_WIDTH) > 2) ? $clog2(MAX_WIDTH) : 2;
	localparam int WID_W      = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
	localparam int MAXW_EVEN  = (MAX_WIDTH / 2) * 2;

	// configuration register
	logic [CFG_W-1:0] image_width_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IMAGE_WIDTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= IMAGE_WIDTH_RST;
		end else if (cfg_wr) begin
			image_width_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_IMAGE_WIDTH) begin
			prdata = {{(APB_DW-CFG_W){1'b0}}, image_width_q};
		end
	end

	// effective width: even, clamped to 2..MAX_WIDTH
	logic [WID_W-1:0] width_raw;
	logic [WID_W-1:0] eff_width;

	always_comb begin
		width_raw = WID_W'({image_width_q[CFG_W-1:1], 1'b0});
		if (width_raw < WID_W'(2)) begin
			eff_width = WID_W'(2);
		end else if (width_raw > WID_W'(MAXW_EVEN)) begin
			eff_width = WID_W'(MAXW_EVEN);
		end else begin
			eff_width = width_raw;
		end
	end

	// pipeline handshake: each stage moves when empty or when the next one moves
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic en_o, en3, en2, en1;
	logic accept;

	assign en_o     = !out_valid_q || !out_stall;
	assign en3      = !v_s3 || en_o;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;
	assign accept   = in_valid && en1;

	// raster position
	logic [COL_W-1:0] col_q;
	logic             odd_q;
	logic [COL_W-1:0] col_cur;
	logic             odd_cur;
	logic [WID_W-1:0] col_next;
	logic             last_col;
	logic [IDX_W-1:0] idx;
	logic             wr_pair;
	logic             rd_pair;
	pix_t             held_q;

	always_comb begin
		col_cur  = frame_start ? '0 : col_q;
		odd_cur  = frame_start ? 1'b0 : odd_q;
		col_next = WID_W'(col_cur) + WID_W'(1);
		last_col = (col_next >= eff_width);
		idx      = IDX_W'(col_cur >> 1);
		wr_pair  = accept && col_cur[0] && !odd_cur;
		rd_pair  = accept && col_cur[0] && odd_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			odd_q  <= 1'b0;
			held_q <= '0;
		end else if (accept) begin
			if (!col_cur[0]) begin
				held_q <= src_pixel;
			end
			if (last_col) begin
				col_q <= '0;
				odd_q <= !odd_cur;
			end else begin
				col_q <= col_next[COL_W-1:0];
				odd_q <= odd_cur;
			end
		end
	end

	// line store of even-row pairs: left pixel low, right pixel high
	logic [2*PIX_W-1:0] pair_line [LINE_DEPTH];
	logic [2*PIX_W-1:0] top_s1;

	always_ff @(posedge clk) begin
		if (wr_pair) begin
			pair_line[idx] <= {src_pixel, held_q};
		end
		if (rd_pair) begin
			top_s1 <= pair_line[idx];
		end
	end

	// stage 1: bottom pair of the block
	pix_t bl_s1, br_s1;
	logic re_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= rd_pair;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pair) begin
			bl_s1 <= held_q;
			br_s1 <= src_pixel;
			re_s1 <= last_col;
		end
	end

	// stage 2: per-channel average
	pix_t q_s2 [CHAN_N];
	pix_t avg_s2;
	logic re_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			q_s2[0] <= top_s1[PIX_W-1:0];
			q_s2[1] <= top_s1[2*PIX_W-1:PIX_W];
			q_s2[2] <= bl_s1;
			q_s2[3] <= br_s1;
			avg_s2  <= block_avg(top_s1[PIX_W-1:0], top_s1[2*PIX_W-1:PIX_W], bl_s1, br_s1);
			re_s2   <= re_s1;
		end
	end

	// stage 3: squared error of each candidate
	pix_t q_s3 [CHAN_N];
	err_t err_s3 [CHAN_N];
	logic re_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			for (int i = 0; i < CHAN_N; i++) begin
				q_s3[i]   <= q_s2[i];
				err_s3[i] <= sq_err(q_s2[i], avg_s2);
			end
			re_s3 <= re_s2;
		end
	end

	// least error wins, earlier candidate on a tie
	pix_t best_pix;
	err_t best_err;

	always_comb begin
		best_pix = q_s3[0];
		best_err = err_s3[0];
		for (int i = 1; i < CHAN_N; i++) begin
			if (err_s3[i] < best_err) begin
				best_pix = q_s3[i];
				best_err = err_s3[i];
			end
		end
	end

	// output register
	pix_t mip_pixel_q;
	logic row_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_o) begin
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_o && v_s3) begin
			mip_pixel_q <= best_pix;
			row_end_q   <= re_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign mip_pixel = mip_pixel_q;
	assign row_end   = row_end_q;

`ifndef NO_ASSERTIONS
	// input backs up only when the first stage holds a result
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1)
		else $error("in_stall raised with stage 1 empty");

	// a bottom-right transfer in an odd row always loads stage 1
	a_block_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && col_cur[0] && odd_cur) |=> v_s1)
		else $error("block result lost at stage 1");

	// no line store write and read in the same transfer
	a_line_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_pair && rd_pair))
		else $error("line store written and read together");

	// a selected error never exceeds four full-scale squared differences
	a_err_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (best_err <= err_t'(260100)))
		else $error("block error out of range");
`endif

endmodule

// ===== sim/mip_average_select_2x2_unit_tb.sv =====
// Self-checking testbench for the 2x2 mip reducer: pixel stream, APB width writes, result checks.
module mip_average_select_2x2_unit_tb;

	import masel_pkg::*;

	localparam int MAX_W       = 1024;
	localparam int LINE_DEPTH  = MAX_W / 2;
	localparam int SETTLE      = 10;   // idle margin after the owed picks have drained
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 17;

	typedef struct packed {
		pix_t pixel;
		logic row_last;
	} mip_result_t;

	// Tracks raster position and line pairs; holds the picks still owed by the block.
	class mip_pick_tracker;
		logic [63:0]      line_pairs [LINE_DEPTH];
		bit               pair_written [LINE_DEPTH];
		pix_t             held_pix;
		int unsigned      col_pos;
		bit               row_odd;
		logic [CFG_W-1:0] width_cfg;
		mip_result_t      pending_picks [$];
		int               mismatches;
		int               picks_checked;

		function new();
			held_pix      = '0;
			col_pos       = 0;
			row_odd       = 1'b0;
			width_cfg     = IMAGE_WIDTH_RST;
			mismatches    = 0;
			picks_checked = 0;
			foreach (pair_written[i])
				pair_written[i] = 1'b0;
		endfunction

		// low bit dropped, clamped to 2..MAX_W
		function int unsigned row_width();
			int unsigned w;
			w = {width_cfg[CFG_W-1:1], 1'b0};
			if (w < 2)
				w = 2;
			if (w > MAX_W)
				w = MAX_W;
			return w;
		endfunction

		// true when this transfer would read a pair never written since reset
		function bit hits_blank(bit fs);
			int unsigned c;
			bit odd;
			c   = fs ? 0 : col_pos;
			odd = fs ? 1'b0 : row_odd;
			return c[0] && odd && ((c >> 1) < LINE_DEPTH) && !pair_written[c >> 1];
		endfunction

		// one accepted source pixel; may add one pick
		function void take_pixel(pix_t pix, bit fs);
			int unsigned w;
			int unsigned c;
			int unsigned idx;
			pix_t quad [4];
			int avg [4];
			int err;
			int best_err;
			int d;
			pix_t best;
			w = row_width();
			if (fs) begin
				col_pos = 0;
				row_odd = 1'b0;
			end
			c = col_pos;
			if (!c[0]) begin
				held_pix = pix;
			end else begin
				idx = c >> 1;
				if (idx < LINE_DEPTH) begin
					if (!row_odd) begin
						line_pairs[idx]   = {pix, held_pix};
						pair_written[idx] = 1'b1;
					end else begin
						quad[0] = line_pairs[idx][31:0];
						quad[1] = line_pairs[idx][63:32];
						quad[2] = held_pix;
						quad[3] = pix;
						// floor average per channel
						for (int k = 0; k < CHAN_N; k++)
							avg[k] = (int'(quad[0][8*k +: 8]) + int'(quad[1][8*k +: 8])
							        + int'(quad[2][8*k +: 8]) + int'(quad[3][8*k +: 8])) >> 2;
						// least squared distance, earlier pixel wins a tie
						best_err = 0;
						best     = quad[0];
						for (int i = 0; i < 4; i++) begin
							err = 0;
							for (int k = 0; k < CHAN_N; k++) begin
								d   = int'(quad[i][8*k +: 8]) - avg[k];
								err = err + d * d;
							end
							if (i == 0 || err < best_err) begin
								best_err = err;
								best     = quad[i];
							end
						end
						pending_picks.push_back('{pixel: best, row_last: (c + 1 >= w)});
					end
				end
			end
			if (c + 1 >= w) begin
				col_pos = 0;
				row_odd = ~row_odd;
			end else begin
				col_pos = c + 1;
			end
		endfunction

		// compare one output transfer with the oldest pick
		function void check_pick(pix_t got_pix, logic got_last);
			mip_result_t want;
			if (pending_picks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output: mip_pixel=%08h row_end=%0b", got_pix, got_last);
				return;
			end
			want = pending_picks.pop_front();
			picks_checked++;
			if (got_pix !== want.pixel || got_last !== want.row_last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch %0d: mip_pixel exp %08h got %08h, row_end exp %0b got %0b",
					         picks_checked, want.pixel, got_pix, want.row_last, got_last);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              psel        = 1'b0;
	logic              penable     = 1'b0;
	logic              pwrite      = 1'b0;
	logic [APB_AW-1:0] paddr       = '0;
	logic [APB_DW-1:0] pwdata      = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	pix_t              src_pixel   = '0;
	logic              frame_start = 1'b0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	pix_t              mip_pixel;
	logic              row_end;

	mip_pick_tracker picks;
	int idle_pct     = 0;
	int stall_pct    = 0;
	int quiet_cycles = 0;
	int pixels_sent  = 0;
	int width_writes = 0;
	int frame_left   = 0;

	mip_average_select_2x2_unit #(
		.MAX_WIDTH(MAX_W)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.src_pixel  (src_pixel),
		.frame_start(frame_start),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.mip_pixel  (mip_pixel),
		.row_end    (row_end)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// output side: check transfers, random stall, activity count for the watchdog
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			picks.check_pick(mip_pixel, row_end);
		if (!arst_n || (out_valid && !out_stall) || (in_valid && !in_stall) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// hang detection
	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("tb: failure");
		$finish;
	end

	// random gaps, then one transfer on the input side
	task automatic send_pixel(input pix_t pix, input bit fs);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		src_pixel   <= pix;
		frame_start <= fs;
		do
			@(posedge clk);
		while (in_stall);
		picks.take_pixel(pix, fs);
		pixels_sent++;
	endtask

	// stop sending and let every owed pick drain
	task automatic quiesce();
		in_valid <= 1'b0;
		while (picks.pending_picks.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// APB setup + access; unused upper data bits carry noise
	task automatic write_width(input logic [CFG_W-1:0] w);
		logic [APB_DW-1:0] word;
		word         = $urandom;
		word[CFG_W-1:0] = w;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_IMAGE_WIDTH, 2'b00};
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		picks.width_cfg = w;
		width_writes++;
	endtask

	// mix of full random, tie-prone palette and saturated channels
	function automatic pix_t rand_pixel();
		pix_t p;
		case ($urandom_range(3))
			2: begin
				case ($urandom_range(3))
					0: p = 32'h0000_0000;
					1: p = 32'hFFFF_FFFF;
					2: p = 32'h7F7F_7F7F;
					default: p = 32'h8080_8080;
				endcase
			end
			3: begin
				for (int k = 0; k < CHAN_N; k++)
					p[8*k +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
			end
			default: p = $urandom;
		endcase
		return p;
	endfunction

	initial begin
		logic [CFG_W-1:0] corner_w [8];
		bit fs;
		corner_w = '{11'd0, 11'd1, 11'd3, 11'd7, 11'd4, 11'd2, 11'd9, 11'd16};
		picks = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset width: four equal pixels, top-left wins the tie
		send_pixel(32'hFFFF_FFFF, 1'b1);
		send_pixel(32'hFFFF_FFFF, 1'b0);
		send_pixel(32'hFFFF_FFFF, 1'b0);
		send_pixel(32'hFFFF_FFFF, 1'b0);

		// width 4: tie between top-left and bottom-right, then bottom-right closest
		quiesce();
		write_width(11'd4);
		send_pixel(32'h0000_0000, 1'b1);
		send_pixel(32'hFFFF_FFFF, 1'b0);
		send_pixel(32'h0000_0000, 1'b0);
		send_pixel(32'hFFFF_FFFF, 1'b0);
		send_pixel(32'hFFFF_FFFF, 1'b0);
		send_pixel(32'h0000_0000, 1'b0);
		send_pixel(32'h0000_0000, 1'b0);
		send_pixel(32'h4040_4040, 1'b0);

		// width below 2: top-right closest, then bottom-left closest
		quiesce();
		write_width(11'd1);
		send_pixel(32'h0000_0000, 1'b1);
		send_pixel(32'h5050_5050, 1'b0);
		send_pixel(32'h6060_6060, 1'b0);
		send_pixel(32'hA0A0_A0A0, 1'b0);
		send_pixel(32'h0000_0000, 1'b0);
		send_pixel(32'hA0A0_A0A0, 1'b0);
		send_pixel(32'h5050_5050, 1'b0);
		send_pixel(32'h6060_6060, 1'b0);

		// width above max: one full even row, then the start of the odd row
		quiesce();
		write_width(11'd2047);
		send_pixel(rand_pixel(), 1'b1);
		repeat (MAX_W + 3) send_pixel(rand_pixel(), 1'b0);

		// random phases: framed rows, occasional stray frame_start
		for (int ph = 0; ph < PHASES; ph++) begin
			quiesce();
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 77; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 77; end
				default: begin idle_pct = 26; stall_pct = 26; end
			endcase
			if (ph < 8)
				write_width(corner_w[ph]);
			else
				write_width(CFG_W'($urandom_range(2, 24)));
			// about half the phases, chosen at random, keep the old position, so the width can change mid row
			if ($urandom_range(1))
				frame_left = 0;
			repeat (PHASE_ITEMS) begin
				if (frame_left <= 0) begin
					fs = 1'b1;
					frame_left = picks.row_width() * $urandom_range(1, 5);
				end else begin
					fs = ($urandom_range(99) < 2);
				end
				if (picks.hits_blank(fs))
					fs = 1'b1;
				send_pixel(rand_pixel(), fs);
				frame_left--;
			end
		end

		idle_pct  = 0;
		stall_pct = 0;
		quiesce();
		$display("run: %0d source pixels sent, %0d reduced pixels checked, %0d width writes",
		         pixels_sent, picks.picks_checked, width_writes);
		$display("run: widths from below 2 to above max, odd widths, idle and stall mixes");
		if (picks.mismatches == 0 && picks.pending_picks.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/masel_pkg.sv
rtl/core/mip_average_select_2x2_unit.sv
sim/mip_average_select_2x2_unit_tb.sv
